>>> hw/rtl/slbm_pkg.sv
// shared types and constants for the serial loaded bank mapper
// no dependencies
package slbm_pkg;

    localparam logic [1:0] FUNC_CPU_WRITE = 2'd0;
    localparam logic [1:0] FUNC_CPU_READ  = 2'd1;
    localparam logic [1:0] FUNC_PPU_READ  = 2'd2;
    localparam logic [1:0] FUNC_NONE      = 2'd3;

    localparam logic [1:0] REG_CONTROL  = 2'd0;
    localparam logic [1:0] REG_CHR_LOW  = 2'd1;
    localparam logic [1:0] REG_CHR_HIGH = 2'd2;
    localparam logic [1:0] REG_PRG      = 2'd3;

    localparam logic [1:0] PRG_MODE_FIX_FIRST = 2'd2;

    localparam logic [4:0] CONTROL_RESET    = 5'h1C;
    localparam logic [3:0] PRG_SEL_RESET    = 4'hF;
    localparam logic [4:0] BANK_COUNT_RESET = 5'd16;
    localparam logic [4:0] PRG_MODE3_MASK   = 5'h0C;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] address;
        logic [7:0]  data_byte;
    } in_item_t;

    typedef struct packed {
        logic [17:0] rom_offset;
        logic        hit;
        logic [1:0]  mirroring;
    } out_item_t;

    typedef struct packed {
        logic [3:0] shift_bits;
        logic [2:0] shift_count;
        logic [4:0] control;
        logic [4:0] chr_low;
        logic [4:0] chr_high;
        logic [3:0] prg_sel;
        logic [3:0] last_bank;
    } map_state_t;

endpackage

>>> hw/rtl/slbm_regs.sv
// serial load shift register, bank registers and bank count register
// depends on slbm_pkg
module slbm_regs
    import slbm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [4:0] cfg_wdata,
    input  logic       step,
    input  in_item_t   item,
    output map_state_t state,
    output logic [4:0] control_next
);

    logic [3:0] shift_bits_reg, shift_bits_next;
    logic [2:0] shift_count_reg, shift_count_next;
    logic [4:0] ctl_reg, control_next_i;
    logic [4:0] chr_low_reg, chr_low_next;
    logic [4:0] chr_high_reg, chr_high_next;
    logic [3:0] prg_sel_reg, prg_sel_next;
    logic [4:0] bank_count_reg;
    logic [4:0] commit_value;
    logic       write_hit;

    assign write_hit    = step && (item.func == FUNC_CPU_WRITE) && item.address[15];
    assign commit_value = {item.data_byte[0], shift_bits_reg};

    always_comb
    begin
        shift_bits_next  = shift_bits_reg;
        shift_count_next = shift_count_reg;
        control_next_i   = ctl_reg;
        chr_low_next     = chr_low_reg;
        chr_high_next    = chr_high_reg;
        prg_sel_next     = prg_sel_reg;
        if (write_hit)
        begin
            if (item.data_byte[7])
            begin
                shift_bits_next  = '0;
                shift_count_next = '0;
                control_next_i   = ctl_reg | PRG_MODE3_MASK;
            end
            else if (shift_count_reg[2])
            begin
                shift_bits_next  = '0;
                shift_count_next = '0;
                case (item.address[14:13])
                    REG_CONTROL:  control_next_i = commit_value;
                    REG_CHR_LOW:  chr_low_next   = commit_value;
                    REG_CHR_HIGH: chr_high_next  = commit_value;
                    REG_PRG:      prg_sel_next   = commit_value[3:0];
                    default:      prg_sel_next   = commit_value[3:0];
                endcase
            end
            else
            begin
                shift_bits_next  = {item.data_byte[0], shift_bits_reg[3:1]};
                shift_count_next = shift_count_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_bits_reg  <= '0;
            shift_count_reg <= '0;
            ctl_reg         <= CONTROL_RESET;
            chr_low_reg     <= '0;
            chr_high_reg    <= '0;
            prg_sel_reg     <= PRG_SEL_RESET;
            bank_count_reg  <= BANK_COUNT_RESET;
        end
        else
        begin
            shift_bits_reg  <= shift_bits_next;
            shift_count_reg <= shift_count_next;
            ctl_reg         <= control_next_i;
            chr_low_reg     <= chr_low_next;
            chr_high_reg    <= chr_high_next;
            prg_sel_reg     <= prg_sel_next;
            if (cfg_we)
            begin
                bank_count_reg <= cfg_wdata;
            end
        end
    end

    assign control_next      = control_next_i;
    assign state.shift_bits  = shift_bits_reg;
    assign state.shift_count = shift_count_reg;
    assign state.control     = ctl_reg;
    assign state.chr_low     = chr_low_reg;
    assign state.chr_high    = chr_high_reg;
    assign state.prg_sel     = prg_sel_reg;
    assign state.last_bank   = bank_count_reg[3:0] - 4'd1;

endmodule

>>> hw/rtl/slbm_xlate.sv
// address translation of cpu and ppu reads into rom byte offsets
// depends on slbm_pkg
module slbm_xlate
    import slbm_pkg::*;
(
    input  in_item_t   item,
    input  map_state_t state,
    input  logic [4:0] control_next,
    output out_item_t  result
);

    logic [1:0]  prg_mode;
    logic [3:0]  win_bank;
    logic [17:0] offset;
    logic        hit;

    assign prg_mode = state.control[3:2];

    always_comb
    begin
        offset   = '0;
        hit      = 1'b0;
        win_bank = '0;
        case (item.func)
            FUNC_CPU_READ:
            begin
                if (item.address[15])
                begin
                    hit = 1'b1;
                    if (!prg_mode[1])
                    begin
                        offset = {state.prg_sel[3:1], item.address[14:0]};
                    end
                    else
                    begin
                        if (!item.address[14])
                            win_bank = (prg_mode == PRG_MODE_FIX_FIRST) ? 4'd0 : state.prg_sel;
                        else
                            win_bank = (prg_mode == PRG_MODE_FIX_FIRST) ? state.prg_sel
                                                                        : state.last_bank;
                        offset = {win_bank, item.address[13:0]};
                    end
                end
            end
            FUNC_PPU_READ:
            begin
                if (item.address[15:13] == 3'd0)
                begin
                    hit = 1'b1;
                    if (state.control[4])
                    begin
                        if (!item.address[12])
                            offset = {1'b0, state.chr_low, item.address[11:0]};
                        else
                            offset = {1'b0, state.chr_high, item.address[11:0]};
                    end
                    else
                    begin
                        offset = {1'b0, state.chr_low[4:1], item.address[12:0]};
                    end
                end
            end
            default:
            begin
                offset = '0;
                hit    = 1'b0;
            end
        endcase
    end

    assign result.rom_offset = offset;
    assign result.hit        = hit;
    assign result.mirroring  = control_next[1:0];

endmodule

>>> hw/rtl/serial_loaded_bank_mapper_core.sv
// Serial loaded bank mapper. Each item is a cpu write, cpu read, ppu read or
// no-op and gives exactly one result item. An item is registered at the input,
// decoded against the mapper registers when it advances (which also commits any
// register update) and lands in the output register; one item per cycle is
// sustained while out_ready stays high; in_ready drops only while the input
// register is full and the output register is held.
// The bank count register (cfg_we, cfg_wdata) may be written whenever no item
// is in flight. Reset leaves 16K prg mode 3 with the last bank fixed.
// depends on slbm_pkg, slbm_regs, slbm_xlate
module serial_loaded_bank_mapper_core
    import slbm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [4:0] cfg_wdata,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_item_t   in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output out_item_t  out_data
);

    logic       s1_valid_reg, s1_valid_next;
    in_item_t   s1_item_reg;
    logic       out_valid_reg, out_valid_next;
    out_item_t  out_item_reg;
    logic       advance;
    map_state_t state;
    logic [4:0] control_next;
    out_item_t  result;

    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    assign s1_valid_next  = (in_valid && in_ready) || (s1_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !out_ready);

    slbm_regs u_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .step         (advance),
        .item         (s1_item_reg),
        .state        (state),
        .control_next (control_next)
    );

    slbm_xlate u_xlate (
        .item         (s1_item_reg),
        .state        (state),
        .control_next (control_next),
        .result       (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_item_reg <= in_data;
        end
        if (advance)
        begin
            out_item_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    a_miss_zero_offset: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.hit |-> out_data.rom_offset == '0)
        else $error("result without hit carries a nonzero offset");

    a_shift_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        state.shift_count <= 3'd4)
        else $error("shift count past five bits");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> s1_valid_reg && out_valid_reg && !out_ready)
        else $error("input stalled without a held result");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid)
        else $error("advanced item missing from output register");

endmodule

>>> tb/tb.sv
// testbench for serial_loaded_bank_mapper_core: directed table then random bus accesses,
// each result checked against a table value or a local model of registers and decoding
// depends on slbm_pkg and the mapper rtl
`timescale 1ns / 100ps

module tb;
    import slbm_pkg::*;

    typedef struct {
        in_item_t  item;
        bit        fixed;
        out_item_t want;
    } stim_row_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [4:0] cfg_wdata;
    logic       in_valid;
    logic       in_ready;
    in_item_t   in_data;
    logic       out_valid;
    logic       out_ready;
    out_item_t  out_data;

    // mapper state as seen from the bus
    logic [3:0] sh_bits;
    logic [2:0] sh_count;
    logic [4:0] ctrl;
    logic [4:0] chr_lo;
    logic [4:0] chr_hi;
    logic [3:0] prg_sel;
    logic [4:0] bank_count;

    out_item_t  expected_q[$];
    stim_row_t  dir_rows[$];
    logic       row_fixed;
    out_item_t  row_want;
    out_item_t  head;

    int errors = 0;
    int n_accepted = 0;
    int n_results = 0;
    int n_loads = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int stall_req = 0;
    int stall_seen = 0;
    int stall_left = 0;

    serial_loaded_bank_mapper_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic out_item_t translate_access(input in_item_t it);
        out_item_t   r;
        logic [4:0]  val;
        int unsigned off;
        int unsigned bank;
        r = '0;
        off = 0;
        case (it.func)
            FUNC_CPU_WRITE:
                if (it.address >= 16'h8000)
                begin
                    if (it.data_byte[7])
                    begin
                        sh_bits = '0;
                        sh_count = '0;
                        ctrl = ctrl | PRG_MODE3_MASK;
                    end
                    else if (sh_count >= 3'd4)
                    begin
                        val = {it.data_byte[0], sh_bits};
                        case (it.address[14:13])
                            REG_CONTROL:  ctrl = val;
                            REG_CHR_LOW:  chr_lo = val;
                            REG_CHR_HIGH: chr_hi = val;
                            default:      prg_sel = val[3:0];
                        endcase
                        sh_bits = '0;
                        sh_count = '0;
                    end
                    else
                    begin
                        sh_bits = {it.data_byte[0], sh_bits[3:1]};
                        sh_count = sh_count + 3'd1;
                    end
                end
            FUNC_CPU_READ:
                if (it.address >= 16'h8000)
                begin
                    r.hit = 1'b1;
                    if (ctrl[3:2] < PRG_MODE_FIX_FIRST)
                    begin
                        off = (prg_sel >> 1) * 32'h8000 + (it.address - 32'h8000);
                    end
                    else if (it.address < 16'hC000)
                    begin
                        bank = (ctrl[3:2] == PRG_MODE_FIX_FIRST) ? 0 : prg_sel;
                        off = bank * 32'h4000 + (it.address - 32'h8000);
                    end
                    else
                    begin
                        bank = (ctrl[3:2] == PRG_MODE_FIX_FIRST) ? prg_sel
                                                                 : 4'(bank_count - 5'd1);
                        off = bank * 32'h4000 + (it.address - 32'hC000);
                    end
                end
            FUNC_PPU_READ:
                if (it.address < 16'h2000)
                begin
                    r.hit = 1'b1;
                    if (ctrl[4])
                        off = (it.address < 16'h1000) ? chr_lo * 32'h1000 + it.address
                                                      : chr_hi * 32'h1000 + (it.address - 32'h1000);
                    else
                        off = (chr_lo >> 1) * 32'h2000 + it.address;
                end
            default: ;
        endcase
        r.rom_offset = off[17:0];
        r.mirroring = ctrl[1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t mismatch %s: got 0x%0h want 0x%0h", $time, what, got, want);
        errors++;
    endtask

    // input side: every accepted item gets its expectation
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            head = translate_access(in_data);
            expected_q.push_back(row_fixed ? row_want : head);
            n_accepted++;
        end
    end

    // output side
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            n_results++;
            if (expected_q.size() == 0)
            begin
                report_mismatch("unexpected item", int'(out_data), 0);
            end
            else
            begin
                head = expected_q.pop_front();
                if (out_data.rom_offset !== head.rom_offset)
                    report_mismatch("rom_offset", int'(out_data.rom_offset),
                                    int'(head.rom_offset));
                if (out_data.hit !== head.hit)
                    report_mismatch("hit", int'(out_data.hit), int'(head.hit));
                if (out_data.mirroring !== head.mirroring)
                    report_mismatch("mirroring", int'(out_data.mirroring),
                                    int'(head.mirroring));
            end
        end
    end

    // receiver with random stalls and one long hold-off on request
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (stall_seen != stall_req)
        begin
            stall_seen = stall_req;
            stall_left = 300;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic send_item(input in_item_t it, input bit fixed, input out_item_t want);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        row_fixed <= fixed;
        row_want <= want;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic send_rand(input in_item_t it, inout int counted);
        send_item(it, 1'b0, '0);
        if (!(it.func == FUNC_NONE || (it.func == FUNC_CPU_WRITE && it.address < 16'h8000)))
            counted++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_bank_count(input logic [4:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        bank_count = v;
    endtask

    task automatic add_row(input logic [1:0] f, input logic [15:0] a, input logic [7:0] d,
                           input bit fixed, input logic [17:0] off, input logic hit,
                           input logic [1:0] mir);
        stim_row_t r;
        r.item = '{func: f, address: a, data_byte: d};
        r.fixed = fixed;
        r.want = '{rom_offset: off, hit: hit, mirroring: mir};
        dir_rows.push_back(r);
    endtask

    function automatic in_item_t rand_read();
        in_item_t it;
        it.data_byte = 8'($urandom);
        if ($urandom_range(1))
        begin
            it.func = FUNC_CPU_READ;
            it.address = ($urandom_range(99) < 85) ? {1'b1, 15'($urandom)} : 16'($urandom);
        end
        else
        begin
            it.func = FUNC_PPU_READ;
            it.address = ($urandom_range(99) < 85) ? {3'b000, 13'($urandom)} : 16'($urandom);
        end
        return it;
    endfunction

    task automatic run_random(input int n_items);
        in_item_t it;
        int counted;
        int roll;
        int n;
        counted = 0;
        while (counted < n_items)
        begin
            roll = $urandom_range(99);
            if (roll < 45)
            begin
                // full serial load of a random register, reads mixed in
                for (int k = 0; k < 5; k++)
                begin
                    if ($urandom_range(99) < 25)
                        send_rand(rand_read(), counted);
                    it.func = FUNC_CPU_WRITE;
                    it.address = {1'b1, 15'($urandom)};
                    it.data_byte = {1'b0, 7'($urandom)};
                    send_rand(it, counted);
                end
                n_loads++;
            end
            else if (roll < 80)
            begin
                send_rand(rand_read(), counted);
            end
            else if (roll < 88)
            begin
                // broken load cut short by a clearing write
                n = $urandom_range(1, 4);
                for (int k = 0; k < n; k++)
                begin
                    it.func = FUNC_CPU_WRITE;
                    it.address = {1'b1, 15'($urandom)};
                    it.data_byte = {1'b0, 7'($urandom)};
                    send_rand(it, counted);
                end
                it.address = {1'b1, 15'($urandom)};
                it.data_byte = {1'b1, 7'($urandom)};
                send_rand(it, counted);
            end
            else
            begin
                it = in_item_t'($urandom);
                it.func = 2'($urandom);
                send_rand(it, counted);
            end
        end
    endtask

    initial
    begin
        int bank_plan[6];
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        row_fixed = 1'b0;
        row_want = '0;
        sh_bits = '0;
        sh_count = '0;
        ctrl = CONTROL_RESET;
        chr_lo = '0;
        chr_hi = '0;
        prg_sel = PRG_SEL_RESET;
        bank_count = BANK_COUNT_RESET;
        bank_plan = '{1, 31, 16, 0, 16, 7};
        bank_plan[5] = $urandom_range(2, 15);

        // after reset: prg mode 3 with the last bank fixed, 4k chr
        add_row(FUNC_CPU_READ,  16'h8000, 8'h00, 1'b1, 18'h3C000, 1'b1, 2'd0);
        add_row(FUNC_CPU_READ,  16'hFFFF, 8'hFF, 1'b1, 18'h3FFFF, 1'b1, 2'd0);
        add_row(FUNC_CPU_READ,  16'h7FFF, 8'h00, 1'b1, 18'h0,     1'b0, 2'd0);
        add_row(FUNC_PPU_READ,  16'h0000, 8'h00, 1'b1, 18'h0,     1'b1, 2'd0);
        add_row(FUNC_PPU_READ,  16'h2000, 8'h00, 1'b1, 18'h0,     1'b0, 2'd0);
        add_row(FUNC_NONE,      16'hFFFF, 8'hFF, 1'b1, 18'h0,     1'b0, 2'd0);
        add_row(FUNC_CPU_WRITE, 16'h7FFF, 8'h01, 1'b1, 18'h0,     1'b0, 2'd0);
        // control gets 0x13
        add_row(FUNC_CPU_WRITE, 16'h8000, 8'h01, 1'b0, '0, 1'b0, '0);
        add_row(FUNC_CPU_WRITE, 16'h8000, 8'h7F, 1'b0, '0, 1'b0, '0);
        add_row(FUNC_CPU_WRITE, 16'h8000, 8'h00, 1'b0, '0, 1'b0, '0);
        add_row(FUNC_CPU_WRITE, 16'h8000, 8'h7E, 1'b0, '0, 1'b0, '0);
        add_row(FUNC_CPU_WRITE, 16'h9FFF, 8'h01, 1'b0, '0, 1'b0, '0);
        add_row(FUNC_CPU_READ,  16'hC000, 8'h00, 1'b0, '0, 1'b0, '0);
        // partial load, then clear
        add_row(FUNC_CPU_WRITE, 16'hE000, 8'h01, 1'b0, '0, 1'b0, '0);
        add_row(FUNC_CPU_WRITE, 16'hFFFF, 8'hFF, 1'b0, '0, 1'b0, '0);
        // chr low gets 0x15
        add_row(FUNC_CPU_WRITE, 16'hA000, 8'h01, 1'b0, '0, 1'b0, '0);
        add_row(FUNC_CPU_WRITE, 16'hA000, 8'h00, 1'b0, '0, 1'b0, '0);
        add_row(FUNC_CPU_WRITE, 16'hA000, 8'h01, 1'b0, '0, 1'b0, '0);
        add_row(FUNC_CPU_WRITE, 16'hA000, 8'h00, 1'b0, '0, 1'b0, '0);
        add_row(FUNC_CPU_WRITE, 16'hBFFF, 8'h01, 1'b0, '0, 1'b0, '0);
        add_row(FUNC_PPU_READ,  16'h1FFF, 8'h00, 1'b0, '0, 1'b0, '0);
        add_row(FUNC_PPU_READ,  16'h1000, 8'h00, 1'b0, '0, 1'b0, '0);
        add_row(FUNC_CPU_READ,  16'h8000, 8'h00, 1'b0, '0, 1'b0, '0);

        tx_idle_pct <= 9;
        rx_idle_pct <= 81;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_item(dir_rows[i].item, dir_rows[i].fixed, dir_rows[i].want);
        drain();

        for (int p = 0; p < 6; p++)
        begin
            case (p / 2)
                0:
                begin
                    tx_idle_pct <= 9;
                    rx_idle_pct <= 81;
                end
                1:
                begin
                    tx_idle_pct <= 81;
                    rx_idle_pct <= 9;
                end
                default:
                begin
                    tx_idle_pct <= 0;
                    rx_idle_pct <= 0;
                end
            endcase
            write_bank_count(5'(bank_plan[p]));
            if (p == 4)
                stall_req <= stall_req + 1;
            run_random(305);
            drain();
        end

        $display("covered %0d items, %0d results checked, %0d register loads",
                 n_accepted, n_results, n_loads);
        $display("bank counts 1 31 16 0 16 %0d, three idle patterns, one long output stall",
                 bank_plan[5]);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("timeout after %0t", $time);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
